[sv/ctd_pkg.sv]
// Shared widths, face codes and the face-to-component map of the cube texel
// direction block. Used by all modules but ctd_div; depends on nothing.
`default_nettype none
package ctd_pkg;

	localparam int COORD_W    = 12;
	localparam int SIZE_W     = 13;
	localparam int OUT_W      = 16;
	localparam int FRAC_BITS  = 14;
	localparam int S_FRAC     = 30;
	localparam int G_FRAC     = 32;
	localparam int FACE_W     = 3;
	localparam int MAG_W      = SIZE_W;
	localparam int SQ_W       = 2 * MAG_W;
	localparam int CUBE_W     = 3 * MAG_W;
	localparam int G_W        = G_FRAC + 1;
	localparam int M_W        = G_FRAC + 2;
	localparam int PROD_W     = MAG_W + M_W;
	localparam int DEN2_W     = SIZE_W + 2;
	localparam int S_W        = 32;
	localparam int ROOT_W     = 32;
	localparam int RAD_W      = 2 * ROOT_W;
	localparam int R_W        = FRAC_BITS + 1;
	localparam int NUM3_W     = ROOT_W + R_W;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 3 * OUT_W;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);
	localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
	localparam logic [S_W-1:0]    AXIS_ONE   = S_W'(64'd1 << S_FRAC);

	typedef enum logic [FACE_W-1:0] {
		FACE_PX = 3'd0,
		FACE_NX = 3'd1,
		FACE_PY = 3'd2,
		FACE_NY = 3'd3,
		FACE_PZ = 3'd4,
		FACE_NZ = 3'd5
	} face_t;

	typedef enum logic [1:0] {
		SRC_AXIS = 2'd0,
		SRC_U    = 2'd1,
		SRC_V    = 2'd2
	} src_t;

	typedef struct packed {
		src_t src;
		logic neg;
	} comp_sel_t;

	// index 0 is x, 1 is y, 2 is z
	typedef comp_sel_t [2:0] face_map_t;

	function automatic comp_sel_t sel(input src_t s, input logic n);
		comp_sel_t c;
		c.src = s;
		c.neg = n;
		return c;
	endfunction

	function automatic face_map_t face_map(input logic [FACE_W-1:0] face);
		face_map_t m;
		m = '{sel(SRC_AXIS, 1'b0), sel(SRC_AXIS, 1'b0), sel(SRC_AXIS, 1'b0)};
		unique case (face)
			FACE_PX: m = '{sel(SRC_U, 1'b0), sel(SRC_V, 1'b0), sel(SRC_AXIS, 1'b0)};
			FACE_NX: m = '{sel(SRC_U, 1'b1), sel(SRC_V, 1'b0), sel(SRC_AXIS, 1'b1)};
			FACE_PY: m = '{sel(SRC_V, 1'b0), sel(SRC_AXIS, 1'b0), sel(SRC_U, 1'b0)};
			FACE_NY: m = '{sel(SRC_V, 1'b1), sel(SRC_AXIS, 1'b1), sel(SRC_U, 1'b0)};
			FACE_PZ: m = '{sel(SRC_AXIS, 1'b0), sel(SRC_V, 1'b0), sel(SRC_U, 1'b1)};
			FACE_NZ: m = '{sel(SRC_AXIS, 1'b1), sel(SRC_V, 1'b0), sel(SRC_U, 1'b0)};
			default: m = '{sel(SRC_AXIS, 1'b0), sel(SRC_AXIS, 1'b0), sel(SRC_AXIS, 1'b0)};
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

[sv/ctd_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
// The quotient must fit in Q_W bits. Uses no package.
`default_nettype none
module ctd_div #(
	parameter int DEN_W  = 32,
	parameter int Q_W    = 16,
	parameter int SIDE_W = 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   in_valid,
	input  wire logic [DEN_W+Q_W-1:0]   num,
	input  wire logic [DEN_W-1:0]       den,
	input  wire logic [SIDE_W-1:0]      side,
	output logic                        out_valid,
	output logic [Q_W-1:0]              quot,
	output logic [SIDE_W-1:0]           out_side
);

	logic [DEN_W-1:0]  rem_s  [Q_W+1];
	logic [Q_W-1:0]    low_s  [Q_W+1];
	logic [DEN_W-1:0]  den_s  [Q_W+1];
	logic [SIDE_W-1:0] side_s [Q_W+1];
	logic              v_s    [Q_W+1];

	// high part of the dividend is already below the divisor
	assign rem_s[0]  = num[DEN_W+Q_W-1:Q_W];
	assign low_s[0]  = num[Q_W-1:0];
	assign den_s[0]  = den;
	assign side_s[0] = side;
	assign v_s[0]    = in_valid;

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           take;

		assign trial = {rem_s[k], low_s[k][Q_W-1]};
		assign diff  = trial - {1'b0, den_s[k]};
		assign take  = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				low_s[k+1]  <= {low_s[k][Q_W-2:0], take};
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[Q_W] & (rem_s[Q_W] < den_s[Q_W] | 1'b1);
	assign quot      = low_s[Q_W];
	assign out_side  = side_s[Q_W];

endmodule
`default_nettype wire

[sv/ctd_sqrt.sv]
// Pipelined integer square root of a 64-bit radicand, one root bit per stage.
// Depends on ctd_pkg for widths.
`default_nettype none
module ctd_sqrt #(
	parameter int SIDE_W = 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_valid,
	input  wire logic [ctd_pkg::RAD_W-1:0]   rad,
	input  wire logic [SIDE_W-1:0]           side,
	output logic                             out_valid,
	output logic [ctd_pkg::ROOT_W-1:0]       root,
	output logic [SIDE_W-1:0]                out_side
);

	localparam int N   = ctd_pkg::ROOT_W;
	localparam int RW  = N + 2;

	logic [RW-1:0]             rem_s  [N+1];
	logic [N-1:0]              root_s [N+1];
	logic [ctd_pkg::RAD_W-1:0] x_s    [N+1];
	logic [SIDE_W-1:0]         side_s [N+1];
	logic                      v_s    [N+1];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign x_s[0]    = rad;
	assign side_s[0] = side;
	assign v_s[0]    = in_valid;

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [RW+1:0] cur;
		logic [RW+1:0] trial;
		logic [RW+1:0] diff;
		logic          take;

		// bring down the next two radicand bits
		assign cur   = {rem_s[k], x_s[k][ctd_pkg::RAD_W-1 -: 2]};
		assign trial = {2'b00, root_s[k], 2'b01};
		assign diff  = cur - trial;
		assign take  = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? diff[RW-1:0] : cur[RW-1:0];
				root_s[k+1] <= {root_s[k][N-2:0], take};
				x_s[k+1]    <= {x_s[k][ctd_pkg::RAD_W-3:0], 2'b00};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[N] & (rem_s[N] <= {rem_s[N][RW-1:0]}) & (x_s[N] == x_s[N]);
	assign root      = root_s[N];
	assign out_side  = side_s[N];

endmodule
`default_nettype wire

[sv/cube_texel_direction.sv]
// Cube texel to warped unit direction: top level with the face-size register,
// front stages, normalize stages and output register. Uses ctd_pkg, ctd_div, ctd_sqrt.
//
//   channel   dir   payload
//   s_axis    in    tdata: face[2:0] column[14:3] row[26:15]
//   m_axis    out   tdata: dir_x[15:0] dir_y[31:16] dir_z[47:32]; tuser: out_of_range
//   cfg       in    cfg_wr_data: face_size, written when cfg_wr_en is high
//
// One texel word enters per cycle while m_axis is not stalled; each word passes
// through the warp dividers (33 + 32 bits), the 32-stage root and the 15-bit
// normalize dividers. Reset clears the valid bits and sets face_size to 256.
// A stall on m_axis freezes the whole pipeline; s_axis_tready is high whenever
// the output register is empty or being taken.
`default_nettype none
module cube_texel_direction (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [ctd_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // face, column, row
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	output logic [ctd_pkg::OUT_DATA_W-1:0]          m_axis_tdata,  // dir_x, dir_y, dir_z
	output logic                                    m_axis_tuser,  // out_of_range
	input  wire logic                               cfg_wr_en,
	input  wire logic [ctd_pkg::SIZE_W-1:0]         cfg_wr_data
);

	localparam int SW  = ctd_pkg::SIZE_W;
	localparam int MW  = ctd_pkg::MAG_W;
	localparam int FW  = ctd_pkg::FACE_W;
	localparam int SQW = ctd_pkg::SQ_W;
	localparam int CW  = ctd_pkg::CUBE_W;
	localparam int GW  = ctd_pkg::G_W;
	localparam int PW  = ctd_pkg::PROD_W;
	localparam int D2W = ctd_pkg::DEN2_W;
	localparam int SVW = ctd_pkg::S_W;
	localparam int RTW = ctd_pkg::ROOT_W;
	localparam int RW  = ctd_pkg::R_W;
	localparam int N3W = ctd_pkg::NUM3_W;
	localparam int OW  = ctd_pkg::OUT_W;
	localparam int SIDE1C_W = 1 + FW + SW + 1 + MW;
	localparam int SIDE1R_W = 1 + MW;
	localparam int SIDE2C_W = 1 + FW + 1;
	localparam int SQS_W    = 1 + 3 + 3 * SVW;

	logic [SW-1:0] size_q;
	logic          en;
	logic          out_valid_q;

	assign en            = ~out_valid_q | m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= ctd_pkg::SIZE_RESET;
		end else if (cfg_wr_en) begin
			size_q <= cfg_wr_data;
		end
	end

	// stage 1: capture and range check
	logic [FW-1:0]                face_in;
	logic [ctd_pkg::COORD_W-1:0]  col_in, row_in;
	logic                         bad_in;

	assign face_in = s_axis_tdata[FW-1:0];
	assign col_in  = s_axis_tdata[FW +: ctd_pkg::COORD_W];
	assign row_in  = s_axis_tdata[FW + ctd_pkg::COORD_W +: ctd_pkg::COORD_W];
	assign bad_in  = (face_in > ctd_pkg::FACE_NZ) || (size_q < ctd_pkg::SIZE_MIN)
		|| ({1'b0, col_in} >= size_q) || ({1'b0, row_in} >= size_q);

	logic                        v_s1, bad_s1;
	logic [FW-1:0]               face_s1;
	logic [ctd_pkg::COORD_W-1:0] col_s1, row_s1;
	logic [SW-1:0]               n_s1;

	// stage 2: centered texel position, magnitude and sign
	logic signed [SW:0] pc, pr;
	logic               v_s2, bad_s2, negc_s2, negr_s2;
	logic [MW-1:0]      magc_s2, magr_s2, nm1_s2;
	logic [SW-1:0]      n_s2;
	logic [FW-1:0]      face_s2;

	assign pc = signed'({1'b0, col_s1, 1'b1}) - signed'({1'b0, n_s1});
	assign pr = signed'({1'b0, row_s1, 1'b1}) - signed'({1'b0, n_s1});

	// stage 3: squares
	logic           v_s3, bad_s3, negc_s3, negr_s3;
	logic [SQW-1:0] sqc_s3, sqr_s3, nm1sq_s3;
	logic [MW-1:0]  magc_s3, magr_s3, nm1_s3;
	logic [SW-1:0]  n_s3;
	logic [FW-1:0]  face_s3;

	// stage 4: cube of (n-1)
	logic           v_s4, bad_s4, negc_s4, negr_s4;
	logic [SQW-1:0] sqc_s4, sqr_s4;
	logic [CW-1:0]  cube_s4;
	logic [MW-1:0]  magc_s4, magr_s4;
	logic [SW-1:0]  n_s4;
	logic [FW-1:0]  face_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			face_s1  <= face_in;
			col_s1   <= col_in;
			row_s1   <= row_in;
			n_s1     <= size_q;
			bad_s1   <= bad_in;

			magc_s2  <= pc[SW] ? MW'(-pc) : MW'(pc);
			negc_s2  <= pc[SW];
			magr_s2  <= pr[SW] ? MW'(-pr) : MW'(pr);
			negr_s2  <= pr[SW];
			nm1_s2   <= n_s1 - SW'(1);
			n_s2     <= n_s1;
			face_s2  <= face_s1;
			bad_s2   <= bad_s1;

			sqc_s3   <= {{MW{1'b0}}, magc_s2} * {{MW{1'b0}}, magc_s2};
			sqr_s3   <= {{MW{1'b0}}, magr_s2} * {{MW{1'b0}}, magr_s2};
			nm1sq_s3 <= {{MW{1'b0}}, nm1_s2} * {{MW{1'b0}}, nm1_s2};
			nm1_s3   <= nm1_s2;
			magc_s3  <= magc_s2;
			magr_s3  <= magr_s2;
			negc_s3  <= negc_s2;
			negr_s3  <= negr_s2;
			n_s3     <= n_s2;
			face_s3  <= face_s2;
			bad_s3   <= bad_s2;

			cube_s4  <= {{MW{1'b0}}, nm1sq_s3} * {{SQW{1'b0}}, nm1_s3};
			sqc_s4   <= sqc_s3;
			sqr_s4   <= sqr_s3;
			magc_s4  <= magc_s3;
			magr_s4  <= magr_s3;
			negc_s4  <= negc_s3;
			negr_s4  <= negr_s3;
			n_s4     <= n_s3;
			face_s4  <= face_s3;
			bad_s4   <= bad_s3;
		end
	end

	// warp slope g = p^2 * 2^32 / (n-1)^3
	localparam int N1_W = CW + GW;
	logic [N1_W-1:0]     num1c, num1r;
	logic                v1c, v1r;
	logic [GW-1:0]       gc, gr;
	logic [SIDE1C_W-1:0] side1c;
	logic [SIDE1R_W-1:0] side1r;

	assign num1c = {{(N1_W - SQW - ctd_pkg::G_FRAC){1'b0}}, sqc_s4, {ctd_pkg::G_FRAC{1'b0}}};
	assign num1r = {{(N1_W - SQW - ctd_pkg::G_FRAC){1'b0}}, sqr_s4, {ctd_pkg::G_FRAC{1'b0}}};

	ctd_div #(.DEN_W(CW), .Q_W(GW), .SIDE_W(SIDE1C_W)) u_div_gc (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s4),
		.num(num1c), .den(cube_s4),
		.side({bad_s4, face_s4, n_s4, negc_s4, magc_s4}),
		.out_valid(v1c), .quot(gc), .out_side(side1c)
	);

	ctd_div #(.DEN_W(CW), .Q_W(GW), .SIDE_W(SIDE1R_W)) u_div_gr (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s4),
		.num(num1r), .den(cube_s4), .side({negr_s4, magr_s4}),
		.out_valid(v1r), .quot(gr), .out_side(side1r)
	);

	// stage 5: |p| * (2^32 + g) + 2n
	localparam int M_W_L = ctd_pkg::M_W;
	logic [MW-1:0] magc_d1, magr_d1;
	logic [SW-1:0] n_d1;
	logic [M_W_L-1:0] mc, mr;
	logic [PW-1:0]  num2c_s5, num2r_s5;
	logic [D2W-1:0] den2_s5;
	logic           v_s5, bad_s5, negc_s5, negr_s5;
	logic [FW-1:0]  face_s5;

	assign magc_d1 = side1c[MW-1:0];
	assign n_d1    = side1c[MW+1 +: SW];
	assign magr_d1 = side1r[MW-1:0];
	assign mc = {2'b01, {ctd_pkg::G_FRAC{1'b0}}} + {1'b0, gc};
	assign mr = {2'b01, {ctd_pkg::G_FRAC{1'b0}}} + {1'b0, gr};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v1c & v1r;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num2c_s5 <= {{M_W_L{1'b0}}, magc_d1} * {{MW{1'b0}}, mc}
				+ {{(PW - SW - 1){1'b0}}, n_d1, 1'b0};
			num2r_s5 <= {{M_W_L{1'b0}}, magr_d1} * {{MW{1'b0}}, mr}
				+ {{(PW - SW - 1){1'b0}}, n_d1, 1'b0};
			den2_s5  <= {n_d1, 2'b00};
			negc_s5  <= side1c[MW];
			face_s5  <= side1c[MW+1+SW +: FW];
			bad_s5   <= side1c[SIDE1C_W-1];
			negr_s5  <= side1r[MW];
		end
	end

	// warped coordinate |s| = round(|p| * m / (4n)), Q.30
	logic           v2c, v2r;
	logic [SVW-1:0] su, sv;
	logic [SIDE2C_W-1:0] side2c;
	logic           negr_d2;

	ctd_div #(.DEN_W(D2W), .Q_W(SVW), .SIDE_W(SIDE2C_W)) u_div_su (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s5),
		.num(num2c_s5), .den(den2_s5), .side({bad_s5, face_s5, negc_s5}),
		.out_valid(v2c), .quot(su), .out_side(side2c)
	);

	ctd_div #(.DEN_W(D2W), .Q_W(SVW), .SIDE_W(1)) u_div_sv (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s5),
		.num(num2r_s5), .den(den2_s5), .side(negr_s5),
		.out_valid(v2r), .quot(sv), .out_side(negr_d2)
	);

	// stage 6: pick components, stage 7: squares, stage 8: sum
	ctd_pkg::face_map_t fmap;
	logic [SVW-1:0]     a_s6 [3];
	logic [SVW-1:0]     a_s7 [3];
	logic [SVW-1:0]     a_s8 [3];
	logic [2:0]         ng_s6, ng_s7, ng_s8;
	logic [2*SVW-1:0]   sq_s7 [3];
	logic [2*SVW-1:0]   sum_s8;
	logic               v_s6, v_s7, v_s8, bad_s6, bad_s7, bad_s8;

	assign fmap = ctd_pkg::face_map(side2c[SIDE2C_W-2 -: FW]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s6 <= v2c & v2r;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				case (fmap[k].src)
					ctd_pkg::SRC_U: begin
						a_s6[k]  <= su;
						ng_s6[k] <= fmap[k].neg ^ side2c[0];
					end
					ctd_pkg::SRC_V: begin
						a_s6[k]  <= sv;
						ng_s6[k] <= fmap[k].neg ^ negr_d2;
					end
					default: begin
						a_s6[k]  <= ctd_pkg::AXIS_ONE;
						ng_s6[k] <= fmap[k].neg;
					end
				endcase
				sq_s7[k] <= {{SVW{1'b0}}, a_s6[k]} * {{SVW{1'b0}}, a_s6[k]};
				a_s7[k]  <= a_s6[k];
				a_s8[k]  <= a_s7[k];
			end
			bad_s6 <= side2c[SIDE2C_W-1];
			ng_s7  <= ng_s6;
			bad_s7 <= bad_s6;
			sum_s8 <= sq_s7[0] + sq_s7[1] + sq_s7[2];
			ng_s8  <= ng_s7;
			bad_s8 <= bad_s7;
		end
	end

	// length
	logic             v_rt;
	logic [RTW-1:0]   root;
	logic [SQS_W-1:0] side_rt;

	ctd_sqrt #(.SIDE_W(SQS_W)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s8), .rad(sum_s8),
		.side({bad_s8, ng_s8, a_s8[2], a_s8[1], a_s8[0]}),
		.out_valid(v_rt), .root(root), .out_side(side_rt)
	);

	// stage 9: rounded dividends for the normalize
	logic [RTW-1:0] len;
	logic [N3W-1:0] num3_s9 [3];
	logic [RTW-1:0] len_s9;
	logic [2:0]     ng_s9;
	logic           v_s9, bad_s9;

	assign len = (root == '0) ? RTW'(1) : root;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_rt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				num3_s9[k] <= {{(N3W - SVW - ctd_pkg::FRAC_BITS){1'b0}},
					side_rt[k*SVW +: SVW], {ctd_pkg::FRAC_BITS{1'b0}}}
					+ {{(N3W - RTW + 1){1'b0}}, len[RTW-1:1]};
			end
			len_s9 <= len;
			ng_s9  <= side_rt[3*SVW +: 3];
			bad_s9 <= side_rt[SQS_W-1];
		end
	end

	// normalize each component
	logic          v3 [3];
	logic [RW-1:0] r3 [3];
	logic [1:0]    side3 [3];

	for (genvar k = 0; k < 3; k++) begin : g_norm
		ctd_div #(.DEN_W(RTW), .Q_W(RW), .SIDE_W(2)) u_div_n (
			.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s9),
			.num(num3_s9[k]), .den(len_s9), .side({bad_s9, ng_s9[k]}),
			.out_valid(v3[k]), .quot(r3[k]), .out_side(side3[k])
		);
	end

	// output register
	logic [OW-1:0] dir_q [3];
	logic          oor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v3[0] & v3[1] & v3[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				if (side3[k][1]) begin
					dir_q[k] <= '0;
				end else if (side3[k][0]) begin
					dir_q[k] <= OW'(0) - {{(OW - RW){1'b0}}, r3[k]};
				end else begin
					dir_q[k] <= {{(OW - RW){1'b0}}, r3[k]};
				end
			end
			oor_q <= side3[0][1];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {dir_q[2], dir_q[1], dir_q[0]};
	assign m_axis_tuser  = oor_q;

endmodule
`default_nettype wire

[sv/ctd_checker.sv]
// Port-level checks on cube_texel_direction, bound to the top level.
// Depends on ctd_pkg for widths.
`default_nettype none
module cube_texel_direction_sva (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               s_axis_tready,
	input wire logic                               m_axis_tvalid,
	input wire logic                               m_axis_tready,
	input wire logic [ctd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input wire logic                               m_axis_tuser
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("m_axis word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("m_axis word changed while stalled");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("rejected texel with nonzero direction");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without an output stall");

endmodule

bind cube_texel_direction cube_texel_direction_sva u_ctd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);
`default_nettype wire

[bench/ctd_checker.sv]
// Checker for cube_texel_direction: tracks face_size, predicts each texel's
// warped unit direction and compares every output word. Depends on ctd_pkg.
`default_nettype none
module ctd_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	input  wire logic                           s_axis_tready,
	input  wire logic [ctd_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // face, column, row
	input  wire logic                           m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	input  wire logic [ctd_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // dir_x, dir_y, dir_z
	input  wire logic                           m_axis_tuser,   // out_of_range
	input  wire logic                           cfg_wr_en,
	input  wire logic [ctd_pkg::SIZE_W-1:0]     cfg_wr_data,
	output int                                  errors,
	output int                                  pending
);
	import ctd_pkg::*;

	typedef struct packed {
		logic [OUT_W-1:0] dir_x;
		logic [OUT_W-1:0] dir_y;
		logic [OUT_W-1:0] dir_z;
		logic             out_of_range;
	} dir_word_t;

	dir_word_t           dir_queue[$];
	logic [SIZE_W-1:0]   size_copy;

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// warped texel-center coordinate in Q.30
	function automatic longint signed warp_coord(input longint unsigned i,
			input longint unsigned n);
		longint signed   p;
		longint unsigned mag, nm1, cube, g, m, q;
		p = longint'(2 * i + 1) - longint'(n);
		mag = (p < 0) ? longint'(-p) : longint'(p);
		nm1 = n - 1;
		cube = nm1 * nm1 * nm1;
		g = ((mag * mag) << G_FRAC) / cube;
		m = (64'd1 << G_FRAC) + g;
		q = (mag * m + 2 * n) / (4 * n);
		return (p < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic dir_word_t texel_direction(input logic [FACE_W-1:0] face,
			input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
			input logic [SIZE_W-1:0] size);
		dir_word_t       w;
		longint unsigned n, sum, len, a, r;
		longint signed   su, sv;
		longint signed   c [3];
		int              uv [3];
		int              vv [3];
		int              av [3];
		logic [OUT_W-1:0] comp;
		w = '0;
		n = size;
		if (face > FACE_NZ || n < 2 || col >= n || row >= n) begin
			w.out_of_range = 1'b1;
			return w;
		end
		case (face_t'(face))
			FACE_PX: begin uv = '{0, 0, 1};  vv = '{0, 1, 0};  av = '{1, 0, 0};  end
			FACE_NX: begin uv = '{0, 0, -1}; vv = '{0, 1, 0};  av = '{-1, 0, 0}; end
			FACE_PY: begin uv = '{1, 0, 0};  vv = '{0, 0, 1};  av = '{0, 1, 0};  end
			FACE_NY: begin uv = '{1, 0, 0};  vv = '{0, 0, -1}; av = '{0, -1, 0}; end
			FACE_PZ: begin uv = '{-1, 0, 0}; vv = '{0, 1, 0};  av = '{0, 0, 1};  end
			default: begin uv = '{1, 0, 0};  vv = '{0, 1, 0};  av = '{0, 0, -1}; end
		endcase
		su = warp_coord(col, n);
		sv = warp_coord(row, n);
		sum = 0;
		for (int k = 0; k < 3; k++) begin
			c[k] = longint'(av[k]) * (64'sd1 <<< S_FRAC) + longint'(uv[k]) * su
				+ longint'(vv[k]) * sv;
			a = (c[k] < 0) ? longint'(-c[k]) : longint'(c[k]);
			sum = sum + a * a;
		end
		len = int_sqrt(sum);
		if (len == 0)
			len = 1;
		for (int k = 0; k < 3; k++) begin
			a = (c[k] < 0) ? longint'(-c[k]) : longint'(c[k]);
			r = ((a << FRAC_BITS) + len / 2) / len;
			comp = (c[k] < 0) ? OUT_W'(-r) : OUT_W'(r);
			if (k == 0)
				w.dir_x = comp;
			else if (k == 1)
				w.dir_y = comp;
			else
				w.dir_z = comp;
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dir_word_t want, got;
		if (!arst_n) begin
			size_copy = SIZE_RESET;
			errors = 0;
			dir_queue.delete();
		end else begin
			if (cfg_wr_en)
				size_copy = cfg_wr_data;
			if (s_axis_tvalid && s_axis_tready)
				dir_queue.push_back(texel_direction(s_axis_tdata[2:0], s_axis_tdata[14:3],
					s_axis_tdata[26:15], size_copy));
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
					m_axis_tuser};
				if (dir_queue.size() == 0) begin
					errors++;
					$display("%0t: unexpected word %h", $realtime, got);
				end else begin
					want = dir_queue.pop_front();
					if (got.dir_x !== want.dir_x) begin
						errors++;
						$display("%0t: dir_x expected %h actual %h", $realtime,
							want.dir_x, got.dir_x);
					end
					if (got.dir_y !== want.dir_y) begin
						errors++;
						$display("%0t: dir_y expected %h actual %h", $realtime,
							want.dir_y, got.dir_y);
					end
					if (got.dir_z !== want.dir_z) begin
						errors++;
						$display("%0t: dir_z expected %h actual %h", $realtime,
							want.dir_z, got.dir_z);
					end
					if (got.out_of_range !== want.out_of_range) begin
						errors++;
						$display("%0t: out_of_range expected %b actual %b", $realtime,
							want.out_of_range, got.out_of_range);
					end
				end
			end
		end
		pending = dir_queue.size();
	end
endmodule
`default_nettype wire

[bench/testbench.sv]
// Top of the cube_texel_direction bench: clock, reset, texel stimulus over
// several face sizes, and the verdict. Depends on ctd_pkg, ctd_checker and cube_texel_direction.
`default_nettype none
module testbench;
	import ctd_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 250;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // face, column, row
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // dir_x, dir_y, dir_z
	logic                  m_axis_tuser;        // out_of_range
	logic                  cfg_wr_en = 1'b0;
	logic [SIZE_W-1:0]     cfg_wr_data = '0;
	int                    errors, pending, quiet_cycles;
	bit                    steady = 1'b0;
	int                    size_now;

	always #5 clk = ~clk;

	cube_texel_direction DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	ctd_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.errors(errors), .pending(pending)
	);

	always @(negedge clk)
		m_axis_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 29);

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_texel(input logic [FACE_W-1:0] face, input logic [COORD_W-1:0] col,
			input logic [COORD_W-1:0] row);
		bit go;
		go = 1'b0;
		while (!go) begin
			@(negedge clk);
			if (!steady && $urandom_range(0, 99) < 29) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {5'b0, row, col, face};
				go = 1'b1;
			end
		end
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// drop valid and hold until every word in flight has come out
	task automatic drain_all();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_size(input int value);
		drain_all();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= SIZE_W'(value);
		size_now = value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_texels(input int count);
		int lim;
		lim = (size_now > 4096) ? 4096 : ((size_now < 1) ? 1 : size_now);
		for (int i = 0; i < count; i++) begin
			if (i == count / 2 && $urandom_range(0, 3) == 0)
				drain_all();
			if (size_now >= 2 && $urandom_range(0, 99) < 85)
				send_texel(FACE_W'($urandom_range(0, 5)), COORD_W'($urandom_range(0, lim - 1)),
					COORD_W'($urandom_range(0, lim - 1)));
			else
				send_texel(FACE_W'($urandom_range(0, 7)), COORD_W'($urandom_range(0, 4095)),
					COORD_W'($urandom_range(0, 4095)));
		end
	endtask

	initial begin
		int sizes [12];
		sizes = '{2, 4096, 3, 8191, 1, 0, 0, 0, 0, 0, 4097, 256};
		for (int k = 5 + 1; k < 10; k++)
			sizes[k] = $urandom_range(2, 64);
		sizes[9] = $urandom_range(65, 4096);
		size_now = 256;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: every face, corners, center and texels just past the edge
		for (int f = 0; f < 8; f++)
			send_texel(FACE_W'(f), 12'd0, 12'd0);
		send_texel(FACE_PX, 12'd255, 12'd255);
		send_texel(FACE_NY, 12'd128, 12'd127);
		send_texel(FACE_PZ, 12'd0, 12'd255);
		send_texel(FACE_NZ, 12'd255, 12'd0);
		send_texel(FACE_PY, 12'd256, 12'd10);
		send_texel(FACE_NX, 12'd10, 12'd256);
		send_texel(FACE_PX, 12'd4095, 12'd4095);
		send_texel(FACE_NZ, 12'd127, 12'd128);

		for (int k = 0; k < 12; k++) begin
			write_size(sizes[k]);
			steady = (k == 1);
			if (sizes[k] == 4096 || sizes[k] == 8191) begin
				send_texel(FACE_PX, 12'd4095, 12'd0);
				send_texel(FACE_NY, 12'd0, 12'd4095);
			end
			random_texels((sizes[k] < 2) ? 20 : 90);
			if (k == 4)
				drain_all();
		end
		steady = 1'b0;

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire

[filelist.f]
sv/ctd_pkg.sv
sv/ctd_div.sv
sv/ctd_sqrt.sv
sv/cube_texel_direction.sv
sv/ctd_checker.sv
bench/ctd_checker.sv
bench/testbench.sv
